// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the encoder tracker
// expects the asserting module to have ports named clock and reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define EPST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked at every edge, reset included
`define EPST_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/epst_pkg.sv =====
// shared types, constants and helpers for the encoder position and speed tracker
// no dependencies
`timescale 1ns / 1ps

package epst_pkg;

   // difference window
   localparam int WINDOW  = 16;
   localparam int RING_AW = $clog2(WINDOW);

   localparam int TICKS_PER_SECOND = 1000000000;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = 18;
   localparam int SUM_W    = 22;
   localparam int WRAP_W   = 32;
   localparam int POS_W    = 49;
   localparam int ROT_W    = 56;
   localparam int SPD_W    = 32;
   localparam int EDGE_W   = 3;
   localparam int BEAT_W   = 30;
   localparam int DEN_W    = SAMPLE_W + EDGE_W;
   localparam int PROD_W   = BEAT_W + DIFF_W;

   // request codes
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WRAP_LIMIT     = 3'd0,
      CSR_LOW_THRESHOLD  = 3'd1,
      CSR_HIGH_THRESHOLD = 3'd2,
      CSR_COUNTS_PER_REV = 3'd3,
      CSR_EDGE_FACTOR    = 3'd4,
      CSR_BEAT_PERIOD    = 3'd5
   } csr_idx_type;

   localparam logic [SAMPLE_W-1:0] RST_WRAP_LIMIT     = 16'd65535;
   localparam logic [SAMPLE_W-1:0] RST_LOW_THRESHOLD  = 16'd16384;
   localparam logic [SAMPLE_W-1:0] RST_HIGH_THRESHOLD = 16'd49152;
   localparam logic [SAMPLE_W-1:0] RST_COUNTS_PER_REV = 16'd1024;
   localparam logic [EDGE_W-1:0]   RST_EDGE_FACTOR    = 3'd4;
   localparam logic [BEAT_W-1:0]   RST_BEAT_PERIOD    = 30'd1000000;

   // shared divider: radix 4, two quotient bits per cycle
   localparam int DIV_W     = 58;
   localparam int DIVR_W    = 30;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
      logic [RING_AW-1:0] n;
      if (p == RING_AW'(WINDOW - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   // times 360 as shift and add
   function automatic logic signed [DIV_W-1:0] mul_deg(input logic signed [DIV_W-1:0] x);
      return (x <<< 8) + (x <<< 6) + (x <<< 5) + (x <<< 3);
   endfunction

   function automatic logic [DIV_W-1:0] magnitude(input logic signed [DIV_W-1:0] x);
      logic [DIV_W-1:0] u;
      u = x;
      return x[DIV_W-1] ? (~u + 1'b1) : u;
   endfunction

endpackage

// ===== rtl/encoder_position_speed_tracker_unit.sv =====
// Encoder position and speed tracker: takes one counter sample per control beat
// and returns difference, window sum, wrap count, position, degrees and speed.
// Request channel req_* (valid/stall): req_type 0 is a sample, 1 a clear.
// Result channel rsp_* (valid/stall): one result for every request, in order.
// Config channel csr_* (valid/ready): ready is always high; write only while idle.
// Two 58-bit divisions (rotation, then speed) run back to back on one unsigned
// divider at two quotient bits per cycle, on magnitudes with the sign put back;
// the update, multiply, scale and done steps lie on the path as well.
// The first request after reset or after a beat_period write also runs a division
// for the ticks-per-beat quotient, which is then kept.
// One request at a time: req_stall is low only while no request is in work,
// so a new request is taken only once the last has reached the output register.
// A finished result waits in the output register; a stalled rsp side holds it
// and a new request may already be taken meanwhile.
// Reset: config registers go to their defaults, tracker state to zero; the 16-entry
// difference ring is marked empty through per-entry valid bits, no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module encoder_position_speed_tracker_unit
   import epst_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [SAMPLE_W-1:0]         req_counter_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [DIFF_W-1:0]    rsp_count_diff,
   output logic signed [SUM_W-1:0]     rsp_diff_window_sum,
   output logic signed [WRAP_W-1:0]    rsp_wrap_count,
   output logic signed [POS_W-1:0]     rsp_position_counts,
   output logic signed [ROT_W-1:0]     rsp_rotation_deg,
   output logic signed [SPD_W-1:0]     rsp_speed_deg_per_s,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_UPDATE = 8'b0000_0010,
      S_QDIV   = 8'b0000_0100,
      S_MUL    = 8'b0000_1000,
      S_SCALE  = 8'b0001_0000,
      S_RDIV   = 8'b0010_0000,
      S_SDIV   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [SAMPLE_W-1:0] wrap_limit_ff, wrap_limit_in;
   logic [SAMPLE_W-1:0] low_thr_ff, low_thr_in;
   logic [SAMPLE_W-1:0] high_thr_ff, high_thr_in;
   logic [SAMPLE_W-1:0] cpr_ff, cpr_in;
   logic [EDGE_W-1:0]   edge_fac_ff, edge_fac_in;
   logic [BEAT_W-1:0]   beat_per_ff, beat_per_in;

   // captured request
   logic                req_type_ff, req_type_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;

   // tracker state
   logic [SAMPLE_W-1:0]      prev_ff, prev_in;
   logic [SAMPLE_W-1:0]      counter_ff, counter_in;
   logic signed [WRAP_W-1:0] ovf_ff, ovf_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [RING_AW-1:0]       ring_pos_ff, ring_pos_in;
   logic signed [SUM_W-1:0]  ring_sum_ff, ring_sum_in;
   logic [WINDOW-1:0]        ring_vld_ff, ring_vld_in;

   // difference ring store
   logic signed [DIFF_W-1:0] ring_mem [WINDOW];
   logic signed [DIFF_W-1:0] rd_data_ff;
   logic                     rd_vld_ff;
   logic                     ring_wr;

   // ticks per beat, kept until beat_period is written
   logic [BEAT_W-1:0] quot_ff, quot_in;
   logic              quot_vld_ff, quot_vld_in;

   // scaling path
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic                     rot_neg_ff, rot_neg_in;
   logic                     spd_neg_ff, spd_neg_in;
   logic [DIV_W-1:0]         spd_mag_ff, spd_mag_in;
   logic signed [ROT_W-1:0]  rot_ff, rot_in;
   logic signed [SPD_W-1:0]  spd_ff, spd_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DIFF_W-1:0] out_diff_ff, out_diff_in;
   logic signed [SUM_W-1:0]  out_sum_ff, out_sum_in;
   logic signed [WRAP_W-1:0] out_wrap_ff, out_wrap_in;
   logic signed [POS_W-1:0]  out_pos_ff, out_pos_in;
   logic signed [ROT_W-1:0]  out_rot_ff, out_rot_in;
   logic signed [SPD_W-1:0]  out_spd_ff, out_spd_in;

   // combinational helpers
   logic                     req_accept;
   logic                     csr_write;
   logic                     wrap_dn, wrap_up;
   logic signed [DIFF_W-1:0] d_raw, d_new, wl_ext, old_diff;
   logic signed [SUM_W-1:0]  sum_new;
   logic signed [POS_W-1:0]  pos_mul;
   logic signed [PROD_W-1:0] spd_mul;
   logic [DEN_W-1:0]         den_mul;
   logic signed [DIV_W-1:0]  pos_deg, spd_deg;
   logic [DIV_W-1:0]         q_signed;
   logic                     den_zero;

   div_req_type div_req;
   div_rsp_type div_rsp;

   epst_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // wrap detection, near-zero to near-top has priority
   assign wrap_dn = (prev_ff < low_thr_ff) && (sample_ff > high_thr_ff);
   assign wrap_up = !wrap_dn && (prev_ff > high_thr_ff) && (sample_ff < low_thr_ff);
   assign wl_ext  = $signed({2'b00, wrap_limit_ff});
   assign d_raw   = $signed({2'b00, sample_ff}) - $signed({2'b00, prev_ff});
   assign d_new   = wrap_dn ? (d_raw - wl_ext) : (wrap_up ? (d_raw + wl_ext) : d_raw);

   // entry never written reads as zero
   assign old_diff = rd_vld_ff ? rd_data_ff : '0;
   assign sum_new  = ring_sum_ff
                   - $signed({{(SUM_W-DIFF_W){old_diff[DIFF_W-1]}}, old_diff})
                   + $signed({{(SUM_W-DIFF_W){d_new[DIFF_W-1]}}, d_new});

   assign pos_mul = $signed(ovf_ff) * $signed({1'b0, wrap_limit_ff})
                  + $signed({{(POS_W-SAMPLE_W){1'b0}}, counter_ff});
   assign spd_mul = $signed({1'b0, quot_ff}) * diff_ff;
   assign den_mul = DEN_W'(edge_fac_ff) * DEN_W'(cpr_ff);

   assign pos_deg  = mul_deg($signed({{(DIV_W-POS_W){pos_ff[POS_W-1]}}, pos_ff}));
   assign spd_deg  = mul_deg($signed({{(DIV_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}));
   assign den_zero = (den_ff == '0);

   always_comb begin
      state_in     = state_ff;
      wrap_limit_in = wrap_limit_ff;
      low_thr_in   = low_thr_ff;
      high_thr_in  = high_thr_ff;
      cpr_in       = cpr_ff;
      edge_fac_in  = edge_fac_ff;
      beat_per_in  = beat_per_ff;
      req_type_in  = req_type_ff;
      sample_in    = sample_ff;
      prev_in      = prev_ff;
      counter_in   = counter_ff;
      ovf_in       = ovf_ff;
      diff_in      = diff_ff;
      ring_pos_in  = ring_pos_ff;
      ring_sum_in  = ring_sum_ff;
      ring_vld_in  = ring_vld_ff;
      ring_wr      = 1'b0;
      quot_in      = quot_ff;
      quot_vld_in  = quot_vld_ff;
      pos_in       = pos_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rot_neg_in   = rot_neg_ff;
      spd_neg_in   = spd_neg_ff;
      spd_mag_in   = spd_mag_ff;
      rot_in       = rot_ff;
      spd_in       = spd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_diff_in  = out_diff_ff;
      out_sum_in   = out_sum_ff;
      out_wrap_in  = out_wrap_ff;
      out_pos_in   = out_pos_ff;
      out_rot_in   = out_rot_ff;
      out_spd_in   = out_spd_ff;
      div_req      = '0;
      q_signed     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_type_in = req_type;
               sample_in   = req_counter_sample;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (req_type_ff == REQ_CLEAR) begin
               prev_in    = '0;
               counter_in = '0;
               ovf_in     = '0;
               diff_in    = '0;
            end else begin
               prev_in    = sample_ff;
               counter_in = sample_ff;
               diff_in    = d_new;
               if (wrap_dn) begin
                  ovf_in = ovf_ff - 1'b1;
               end else if (wrap_up) begin
                  ovf_in = ovf_ff + 1'b1;
               end
               ring_wr                  = 1'b1;
               ring_vld_in[ring_pos_ff] = 1'b1;
               ring_sum_in              = sum_new;
               ring_pos_in              = ring_next(ring_pos_ff);
            end
            if (quot_vld_ff) begin
               state_in = S_MUL;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(TICKS_PER_SECOND);
               div_req.divisor  = beat_per_ff;
               state_in         = S_QDIV;
            end
         end
         S_QDIV: begin
            if (div_rsp.done) begin
               quot_in     = (beat_per_ff == '0) ? '0 : div_rsp.quotient[BEAT_W-1:0];
               quot_vld_in = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            pos_in   = pos_mul;
            prod_in  = spd_mul;
            den_in   = den_mul;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            rot_neg_in       = pos_deg[DIV_W-1];
            spd_neg_in       = spd_deg[DIV_W-1];
            spd_mag_in       = magnitude(spd_deg);
            div_req.start    = 1'b1;
            div_req.dividend = magnitude(pos_deg);
            div_req.divisor  = DIVR_W'(den_ff);
            state_in         = S_RDIV;
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               q_signed = rot_neg_ff ? (DIV_W'(0) - div_rsp.quotient) : div_rsp.quotient;
               rot_in   = den_zero ? '0 : $signed(q_signed[ROT_W-1:0]);
               div_req.start    = 1'b1;
               div_req.dividend = spd_mag_ff;
               div_req.divisor  = DIVR_W'(den_ff);
               state_in         = S_SDIV;
            end
         end
         S_SDIV: begin
            if (div_rsp.done) begin
               q_signed = spd_neg_ff ? (DIV_W'(0) - div_rsp.quotient) : div_rsp.quotient;
               spd_in   = den_zero ? '0 : $signed(q_signed[SPD_W-1:0]);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_diff_in  = diff_ff;
               out_sum_in   = ring_sum_ff;
               out_wrap_in  = ovf_ff;
               out_pos_in   = pos_ff;
               out_rot_in   = rot_ff;
               out_spd_in   = spd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         case (csr_index)
            CSR_WRAP_LIMIT:     wrap_limit_in = csr_wdata[SAMPLE_W-1:0];
            CSR_LOW_THRESHOLD:  low_thr_in    = csr_wdata[SAMPLE_W-1:0];
            CSR_HIGH_THRESHOLD: high_thr_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_COUNTS_PER_REV: cpr_in        = csr_wdata[SAMPLE_W-1:0];
            CSR_EDGE_FACTOR:    edge_fac_in   = csr_wdata[EDGE_W-1:0];
            CSR_BEAT_PERIOD: begin
               beat_per_in = csr_wdata[BEAT_W-1:0];
               quot_vld_in = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wrap_limit_ff <= RST_WRAP_LIMIT;
         low_thr_ff    <= RST_LOW_THRESHOLD;
         high_thr_ff   <= RST_HIGH_THRESHOLD;
         cpr_ff        <= RST_COUNTS_PER_REV;
         edge_fac_ff   <= RST_EDGE_FACTOR;
         beat_per_ff   <= RST_BEAT_PERIOD;
         prev_ff       <= '0;
         counter_ff    <= '0;
         ovf_ff        <= '0;
         diff_ff       <= '0;
         ring_pos_ff   <= '0;
         ring_sum_ff   <= '0;
         ring_vld_ff   <= '0;
         quot_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wrap_limit_ff <= wrap_limit_in;
         low_thr_ff    <= low_thr_in;
         high_thr_ff   <= high_thr_in;
         cpr_ff        <= cpr_in;
         edge_fac_ff   <= edge_fac_in;
         beat_per_ff   <= beat_per_in;
         prev_ff       <= prev_in;
         counter_ff    <= counter_in;
         ovf_ff        <= ovf_in;
         diff_ff       <= diff_in;
         ring_pos_ff   <= ring_pos_in;
         ring_sum_ff   <= ring_sum_in;
         ring_vld_ff   <= ring_vld_in;
         quot_vld_ff   <= quot_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_type_ff <= req_type_in;
      sample_ff   <= sample_in;
      quot_ff     <= quot_in;
      pos_ff      <= pos_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rot_neg_ff  <= rot_neg_in;
      spd_neg_ff  <= spd_neg_in;
      spd_mag_ff  <= spd_mag_in;
      rot_ff      <= rot_in;
      spd_ff      <= spd_in;
      out_diff_ff <= out_diff_in;
      out_sum_ff  <= out_sum_in;
      out_wrap_ff <= out_wrap_in;
      out_pos_ff  <= out_pos_in;
      out_rot_ff  <= out_rot_in;
      out_spd_ff  <= out_spd_in;
   end

   // ring store: read at the accept edge, written back during update
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_data_ff <= ring_mem[ring_pos_ff];
         rd_vld_ff  <= ring_vld_ff[ring_pos_ff];
      end
      if (ring_wr) begin
         ring_mem[ring_pos_ff] <= d_new;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_count_diff      = out_diff_ff;
   assign rsp_diff_window_sum = out_sum_ff;
   assign rsp_wrap_count      = out_wrap_ff;
   assign rsp_position_counts = out_pos_ff;
   assign rsp_rotation_deg    = out_rot_ff;
   assign rsp_speed_deg_per_s = out_spd_ff;

   `EPST_ASSERT(a_accept_blocks, req_accept |=> req_stall, "request taken while busy")
   `EPST_ASSERT(a_div_free, div_req.start |-> !div_rsp.busy, "divider started while busy")
   `EPST_ASSERT(a_ring_step, ring_wr |=> ring_pos_ff == ring_next($past(ring_pos_ff)), "ring stuck")
   `EPST_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "early result")
   `EPST_ASSERT_NR(a_rst_clear, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

// ===== rtl/epst_div.sv =====
// sequential unsigned divider, two quotient bits per cycle, shared by the tracker
// depends on epst_pkg
`timescale 1ns / 1ps

module epst_div
   import epst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;

   logic [DIVR_W:0] r1, m1, r2, m2;
   logic            ge1, ge2;

   // two restoring steps
   always_comb begin
      r1  = {rem_ff, quo_ff[DIV_W-1]};
      ge1 = (r1 >= {1'b0, dvs_ff});
      m1  = ge1 ? (r1 - {1'b0, dvs_ff}) : r1;
      r2  = {m1[DIVR_W-1:0], quo_ff[DIV_W-2]};
      ge2 = (r2 >= {1'b0, dvs_ff});
      m2  = ge2 ? (r2 - {1'b0, dvs_ff}) : r2;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CW'(DIV_STEPS - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = m2[DIVR_W-1:0];
         quo_in = {quo_ff[DIV_W-3:0], ge1, ge2};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
